// ----- hdl/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int LINES_DEF   = 25;

	localparam logic [7:0]  CHR_BS     = 8'h08;
	localparam logic [7:0]  CHR_TAB    = 8'h09;
	localparam logic [7:0]  CHR_NL     = 8'h0A;
	localparam logic [7:0]  CHR_CR     = 8'h0D;
	localparam logic [7:0]  CHR_SPACE  = 8'h20;
	localparam logic [15:0] BLANK_WORD = 16'h0720;

	localparam logic [7:0] ATTR_RST = 8'h07;
	localparam logic [3:0] TAB_RST  = 4'd8;

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic {
		CFG_TEXT_ATTRIBUTE = 1'b0,
		CFG_TAB_WIDTH      = 1'b1
	} cfg_index_t;

	typedef struct packed {
		op_t         opcode;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [10:0] cursor_position;
		logic [15:0] cell_word;
		logic        scrolled;
	} rsp_t;

	typedef struct packed {
		cfg_index_t index;
		logic [7:0] wdata;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_PUT,
		ST_SCROLL_MOVE,
		ST_SCROLL_LAST,
		ST_SCROLL_BLANK,
		ST_READ,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/tccw_chan_if.sv -----
// ----------------------------------------------------------------------------
// tccw_chan_if
// Valid/ready channel carrying one request payload.
// ----------------------------------------------------------------------------
interface tccw_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/text_console_char_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer_core
// Text screen store with linear cursor, fed one character byte per request.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                      request when
//  cmd      in   opcode, char_code, cell_index                valid & ready
//  rsp      out  cursor_position, cell_word, scrolled         valid & ready
//  cfg      in   index (0 attribute, 1 tab width), wdata      valid & ready
//
//  A tab puts tab_width spaces. A newline on the last line, or a character
//  past the last cell, scrolls the screen; a scroll moves one cell per cycle
//  through the single memory port pair.
//  Reset sweeps the memory to blanks with cmd not ready; cfg is always
//  ready. A finished result waits in the rsp register while cmd takes the
//  next request.
// ----------------------------------------------------------------------------
module text_console_char_writer_core #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int LINES   = tccw_pkg::LINES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tccw_chan_if.sink   cmd,
	tccw_chan_if.source rsp,
	tccw_chan_if.sink   cfg
);
	import tccw_pkg::*;

	localparam int CELLS = COLUMNS * LINES;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int COLW  = $clog2(COLUMNS);

	localparam logic [CW-1:0]   CUR_END   = CW'(CELLS);
	localparam logic [CW-1:0]   CUR_LAST  = CW'(CELLS - COLUMNS);
	localparam logic [CW-1:0]   CUR_COLS  = CW'(COLUMNS);
	localparam logic [AW-1:0]   PTR_LAST  = AW'(CELLS - 1);
	localparam logic [AW-1:0]   PTR_COLS  = AW'(COLUMNS);
	localparam logic [AW-1:0]   PTR_LLINE = AW'(CELLS - COLUMNS);
	localparam logic [COLW-1:0] COL_LAST  = COLW'(COLUMNS - 1);

	state_t state_q, state_d;

	logic [CW-1:0]   cursor_q;
	logic [COLW-1:0] col_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   wr_addr_s1;
	logic [3:0]      cnt_q;
	logic            then_put_q;
	logic            scrolled_q;
	logic [15:0]     word_q;
	op_t             op_q;
	logic [7:0]      ch_q;
	logic [10:0]     idx_q;
	logic [7:0]      attr_q;
	logic [3:0]      tab_width_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic [15:0] mem [CELLS];
	logic [15:0] rd_data_q;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0] wr_data;
	logic [AW-1:0] rd_addr;

	logic          cmd_take;
	logic          rsp_free;
	logic          cur_end;
	logic [CW-1:0] nl_next;
	logic          nl_wrap;
	logic          idx_ok;
	logic          bs_hit;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign cur_end = (cursor_q == CUR_END);
	assign nl_next = cursor_q - CW'(col_q) + CUR_COLS;
	assign nl_wrap = (nl_next == CUR_END);
	assign idx_ok  = (32'(idx_q) < 32'(CELLS));
	assign bs_hit  = (op_q == OP_PUT) && (ch_q == CHR_BS) && (cursor_q != '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (ptr_q == PTR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_take) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (op_q == OP_READ) begin
					state_d = ST_READ;
				end else begin
					case (ch_q) inside
						CHR_CR, CHR_BS: state_d = ST_DONE;
						CHR_NL: state_d = (cur_end || nl_wrap) ? ST_SCROLL_MOVE : ST_DONE;
						CHR_TAB: state_d = (tab_width_q == '0) ? ST_DONE : ST_PUT;
						default: state_d = ST_PUT;
					endcase
				end
			end
			ST_PUT: begin
				if (cur_end) state_d = ST_SCROLL_MOVE;
				else if (cnt_q == 4'd1) state_d = ST_DONE;
			end
			ST_SCROLL_MOVE: begin
				if (ptr_q == PTR_LAST) state_d = ST_SCROLL_LAST;
			end
			ST_SCROLL_LAST: state_d = ST_SCROLL_BLANK;
			ST_SCROLL_BLANK: begin
				if (ptr_q == PTR_LAST) state_d = then_put_q ? ST_PUT : ST_DONE;
			end
			ST_READ: state_d = ST_DONE;
			ST_DONE: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = BLANK_WORD;
		rd_addr = AW'(idx_q);
		unique case (state_q)
			ST_CLEAR, ST_SCROLL_BLANK: begin
				wr_en = 1'b1;
			end
			ST_DISPATCH: begin
				wr_en   = bs_hit;
				wr_addr = AW'(cursor_q - CW'(1));
			end
			ST_PUT: begin
				wr_en   = !cur_end;
				wr_addr = AW'(cursor_q);
				wr_data = {attr_q, ch_q};
			end
			ST_SCROLL_MOVE: begin
				rd_addr = ptr_q;
				wr_en   = (ptr_q != PTR_COLS);
				wr_addr = wr_addr_s1;
				wr_data = rd_data_q;
			end
			ST_SCROLL_LAST: begin
				wr_en   = 1'b1;
				wr_addr = wr_addr_s1;
				wr_data = rd_data_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q  <= mem[rd_addr];
		wr_addr_s1 <= ptr_q - PTR_COLS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= ATTR_RST;
			tab_width_q <= TAB_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				CFG_TEXT_ATTRIBUTE: attr_q <= cfg.data.wdata;
				CFG_TAB_WIDTH:      tab_width_q <= cfg.data.wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cursor_q    <= '0;
			col_q       <= '0;
			ptr_q       <= '0;
			cnt_q       <= '0;
			then_put_q  <= 1'b0;
			scrolled_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && rsp_free) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (ptr_q != PTR_LAST) ptr_q <= ptr_q + AW'(1);
				end
				ST_IDLE: begin
					scrolled_q <= 1'b0;
				end
				ST_DISPATCH: begin
					if (op_q == OP_PUT) begin
						case (ch_q)
							CHR_NL: begin
								col_q <= '0;
								if (cur_end || nl_wrap) begin
									cursor_q   <= CUR_LAST;
									scrolled_q <= 1'b1;
									ptr_q      <= PTR_COLS;
									then_put_q <= 1'b0;
								end else begin
									cursor_q <= nl_next;
								end
							end
							CHR_BS: begin
								if (cursor_q != '0) begin
									cursor_q <= cursor_q - CW'(1);
									col_q    <= (col_q == '0) ? COL_LAST : col_q - COLW'(1);
								end
							end
							CHR_TAB: cnt_q <= tab_width_q;
							CHR_CR: ;
							default: cnt_q <= 4'd1;
						endcase
					end
				end
				ST_PUT: begin
					if (cur_end) begin
						cursor_q   <= CUR_LAST;
						col_q      <= '0;
						scrolled_q <= 1'b1;
						ptr_q      <= PTR_COLS;
						then_put_q <= 1'b1;
					end else begin
						cursor_q <= cursor_q + CW'(1);
						col_q    <= (col_q == COL_LAST) ? '0 : col_q + COLW'(1);
						cnt_q    <= cnt_q - 4'd1;
					end
				end
				ST_SCROLL_MOVE: begin
					ptr_q <= (ptr_q == PTR_LAST) ? PTR_LLINE : ptr_q + AW'(1);
				end
				ST_SCROLL_BLANK: begin
					if (ptr_q != PTR_LAST) ptr_q <= ptr_q + AW'(1);
				end
				default: ;
			endcase
		end
	end

	// request payload and result words
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_q   <= cmd.data.opcode;
			ch_q   <= cmd.data.char_code;
			idx_q  <= cmd.data.cell_index;
			word_q <= '0;
		end
		if (state_q == ST_DISPATCH && op_q == OP_PUT && ch_q == CHR_TAB) ch_q <= CHR_SPACE;
		if (state_q == ST_READ) word_q <= idx_ok ? rd_data_q : 16'h0000;
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q.cursor_position <= 11'(cursor_q);
			rsp_q.cell_word       <= word_q;
			rsp_q.scrolled        <= scrolled_q;
		end
	end

endmodule
